// ----- rtl/radar_report_frame_parser_macros.svh -----
`ifndef RADAR_REPORT_FRAME_PARSER_MACROS_SVH
`define RADAR_REPORT_FRAME_PARSER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define RRFP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define RRFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/rrfp_pkg.sv -----
package rrfp_pkg;

  localparam int NUM_TARGETS = 3;
  localparam int HDR_LEN     = 4;
  localparam int REC_LEN     = 8;
  localparam int REC_BYTES   = NUM_TARGETS * REC_LEN;
  localparam int FRAME_LEN   = HDR_LEN + REC_BYTES + 2;
  localparam int ADDR_W      = $clog2(FRAME_LEN);
  localparam int OFF_W       = $clog2(REC_BYTES);
  localparam int TGT_W       = (NUM_TARGETS > 1) ? $clog2(NUM_TARGETS) : 1;
  localparam int REC_W       = REC_LEN * 8;

  localparam logic [7:0] HDR_B0      = 8'hAA;
  localparam logic [7:0] HDR_B1      = 8'hFF;
  localparam logic [7:0] HDR_B2      = 8'h03;
  localparam logic [7:0] HDR_B3      = 8'h00;
  localparam logic [7:0] TAIL_B0     = 8'h55;
  localparam logic [7:0] TAIL_B1     = 8'hCC;
  localparam logic [7:0] MAG_HI_MASK = 8'h7F;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_BODY,
    ST_FETCH,
    ST_LOAD,
    ST_PUSH
  } parse_st_t;

  function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
    logic [7:0] res;
    unique case (idx)
      2'd0: res = HDR_B0;
      2'd1: res = HDR_B1;
      2'd2: res = HDR_B2;
      2'd3: res = HDR_B3;
    endcase
    return res;
  endfunction

  // sign-magnitude word to two's complement
  function automatic logic signed [15:0] sm_to_tc(input logic [15:0] raw);
    logic [15:0] mag;
    mag = {1'b0, raw[14:0]};
    return raw[15] ? $signed(16'd0 - mag) : $signed(mag);
  endfunction

endpackage

// ----- rtl/rrfp_in_if.sv -----
interface rrfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/rrfp_out_if.sv -----
interface rrfp_out_if;
  logic               valid;
  logic               ready;
  logic               frame_status;
  logic [1:0]         target_index;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] speed;
  logic [15:0]        distance_res;
  logic               target_valid;
  logic [1:0]         valid_count;
  logic [31:0]        good_frames;
  logic [31:0]        bad_frames;
  logic               last;

  modport source (
    output valid, output frame_status, output target_index, output pos_x, output pos_y,
    output speed, output distance_res, output target_valid, output valid_count,
    output good_frames, output bad_frames, output last, input ready
  );
  modport sink (
    input valid, input frame_status, input target_index, input pos_x, input pos_y,
    input speed, input distance_res, input target_valid, input valid_count,
    input good_frames, input bad_frames, input last, output ready
  );
endinterface

// ----- rtl/radar_report_frame_parser.sv -----
// Radar report frame parser. Bytes are taken one per cycle while the block hunts for the
// AA FF 03 00 header and gathers the frame body into a 30-byte frame RAM; the last tail byte
// of every frame waits for the output register to be empty. That byte of a rejected frame
// registers its single error result as it is taken. After a good tail the block reads each
// 8-byte target record back through the RAM's single read port, one byte a cycle, and holds
// input off while it fetches, loads and pushes each target, longer if the result side
// stalls. A new byte is taken while the final target result is still waiting at the output.
`include "radar_report_frame_parser_macros.svh"

module radar_report_frame_parser
  import rrfp_pkg::*;
(
  input logic          clk,
  input logic          rst_n,
  rrfp_in_if.sink      in_ch,
  rrfp_out_if.source   out_ch
);

  parse_st_t state_r, state_nxt;

  logic [1:0]             hm_r;
  logic [ADDR_W-1:0]      pos_r;
  logic                   tail0_r;
  logic [NUM_TARGETS-1:0] vflag_r;
  logic [31:0]            good_r;
  logic [31:0]            bad_r;
  logic [TGT_W-1:0]       tgt_r;
  logic [2:0]             k_r;
  logic                   rd_vld_r;
  logic [REC_W-1:0]       rec_r;

  logic               out_valid_r;
  logic               out_frame_status_r;
  logic [1:0]         out_target_index_r;
  logic signed [15:0] out_pos_x_r;
  logic signed [15:0] out_pos_y_r;
  logic signed [15:0] out_speed_r;
  logic [15:0]        out_distance_res_r;
  logic               out_target_valid_r;
  logic [1:0]         out_valid_count_r;
  logic [31:0]        out_good_frames_r;
  logic [31:0]        out_bad_frames_r;
  logic               out_last_r;

  logic              in_acc;
  logic [7:0]        rx_b;
  logic              hdr_hit;
  logic              hdr_done;
  logic              body_last;
  logic              tail_ok;
  logic              tgt_last;
  logic              out_free;
  logic              in_ready;
  logic              ram_wr;
  logic              ram_rd;
  logic              push_tgt;
  logic              push_err;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              body_rec;
  logic [OFF_W-1:0]  off;
  logic [TGT_W-1:0]  off_tgt;
  logic [7:0]        nz_mask;
  logic              byte_nz;
  logic              in_readout;
  logic              rd_window;
  logic              pos_in_body;
  logic              hunt_last;
  logic              err_shown;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign rx_b      = in_ch.rx_byte;
  assign hdr_hit   = rx_b == hdr_byte(hm_r);
  assign hdr_done  = hdr_hit && (hm_r == 2'd3);
  assign body_last = pos_r == ADDR_W'(FRAME_LEN - 1);
  assign tail_ok   = tail0_r && (rx_b == TAIL_B1);
  assign tgt_last  = tgt_r == TGT_W'(NUM_TARGETS - 1);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign rd_addr   = ADDR_W'(HDR_LEN + REC_LEN * int'(tgt_r) + int'(k_r));

  // per-target nonzero tracking while the body streams in
  assign body_rec = pos_r < ADDR_W'(HDR_LEN + REC_BYTES);
  assign off      = OFF_W'(pos_r - ADDR_W'(HDR_LEN));
  assign off_tgt  = TGT_W'(off >> 3);
  assign nz_mask  = (off[2:0] == 3'd1 || off[2:0] == 3'd3 || off[2:0] == 3'd5) ?
                    MAG_HI_MASK : 8'hFF;
  assign byte_nz  = |(rx_b & nz_mask);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_HUNT: begin
        if (in_acc && hdr_done) state_nxt = ST_BODY;
      end
      ST_BODY: begin
        if (in_acc && body_last) state_nxt = tail_ok ? ST_FETCH : ST_HUNT;
      end
      ST_FETCH: begin
        if (k_r == 3'd7) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_nxt = tgt_last ? ST_HUNT : ST_FETCH;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ram_rd   = 1'b0;
    push_tgt = 1'b0;
    unique case (state_r)
      ST_HUNT:  in_ready = 1'b1;
      ST_BODY:  in_ready = !body_last || !out_valid_r;
      ST_FETCH: ram_rd = 1'b1;
      ST_LOAD:  ;
      ST_PUSH:  push_tgt = out_free;
    endcase
  end

  assign ram_wr   = (state_r == ST_BODY) && in_acc;
  assign push_err = ram_wr && body_last && !tail_ok;

  rrfp_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_LEN)
  ) u_frame_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (pos_r),
    .wr_data (rx_b),
    .rd_en   (ram_rd),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HUNT;
      hm_r        <= '0;
      pos_r       <= '0;
      tail0_r     <= 1'b0;
      vflag_r     <= '0;
      good_r      <= '0;
      bad_r       <= '0;
      tgt_r       <= '0;
      k_r         <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= ram_rd;
      if (state_r == ST_HUNT && in_acc) begin
        if (hdr_hit) begin
          hm_r <= hm_r + 2'd1;
        end else if (rx_b == HDR_B0) begin
          hm_r <= 2'd1;
        end else begin
          hm_r <= 2'd0;
        end
        if (hdr_done) begin
          pos_r   <= ADDR_W'(HDR_LEN);
          vflag_r <= '0;
        end
      end
      if (ram_wr) begin
        pos_r <= body_last ? '0 : pos_r + ADDR_W'(1);
        if (body_rec && byte_nz) vflag_r[off_tgt] <= 1'b1;
        if (pos_r == ADDR_W'(FRAME_LEN - 2)) tail0_r <= rx_b == TAIL_B0;
        if (body_last) begin
          if (tail_ok) begin
            good_r <= good_r + 32'd1;
          end else begin
            bad_r <= bad_r + 32'd1;
          end
          tgt_r <= '0;
          k_r   <= '0;
        end
      end
      if (ram_rd) k_r <= k_r + 3'd1;
      if (push_tgt) begin
        tgt_r <= tgt_r + TGT_W'(1);
        k_r   <= '0;
      end
      if (push_tgt || push_err) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld_r) rec_r <= {rd_data, rec_r[REC_W-1:8]};
    if (push_err) begin
      out_frame_status_r <= 1'b1;
      out_target_index_r <= '0;
      out_pos_x_r        <= '0;
      out_pos_y_r        <= '0;
      out_speed_r        <= '0;
      out_distance_res_r <= '0;
      out_target_valid_r <= 1'b0;
      out_valid_count_r  <= '0;
      out_good_frames_r  <= good_r;
      out_bad_frames_r   <= bad_r + 32'd1;
      out_last_r         <= 1'b1;
    end else if (push_tgt) begin
      out_frame_status_r <= 1'b0;
      out_target_index_r <= 2'(tgt_r);
      out_pos_x_r        <= sm_to_tc(rec_r[15:0]);
      out_pos_y_r        <= sm_to_tc(rec_r[31:16]);
      out_speed_r        <= sm_to_tc(rec_r[47:32]);
      out_distance_res_r <= rec_r[63:48];
      out_target_valid_r <= vflag_r[tgt_r];
      out_valid_count_r  <= 2'($countones(vflag_r));
      out_good_frames_r  <= good_r;
      out_bad_frames_r   <= bad_r;
      out_last_r         <= tgt_last;
    end
  end

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_status = out_frame_status_r;
  assign out_ch.target_index = out_target_index_r;
  assign out_ch.pos_x        = out_pos_x_r;
  assign out_ch.pos_y        = out_pos_y_r;
  assign out_ch.speed        = out_speed_r;
  assign out_ch.distance_res = out_distance_res_r;
  assign out_ch.target_valid = out_target_valid_r;
  assign out_ch.valid_count  = out_valid_count_r;
  assign out_ch.good_frames  = out_good_frames_r;
  assign out_ch.bad_frames   = out_bad_frames_r;
  assign out_ch.last         = out_last_r;

  assign in_readout  = state_r == ST_FETCH || state_r == ST_LOAD || state_r == ST_PUSH;
  assign rd_window   = state_r == ST_FETCH || state_r == ST_LOAD;
  assign pos_in_body = pos_r >= ADDR_W'(HDR_LEN) && pos_r < ADDR_W'(FRAME_LEN);
  assign hunt_last   = state_r == ST_HUNT && out_valid_r && out_last_r;
  assign err_shown   = out_valid_r && out_frame_status_r && out_last_r;

  `RRFP_ASSERT_SAME(a_no_rx_in_emit, in_readout, !in_ch.ready, "byte request taken in readout")
  `RRFP_ASSERT_SAME(a_rd_in_fetch, rd_vld_r, rd_window, "frame ram read data outside readout")
  `RRFP_ASSERT_SAME(a_body_pos, state_r == ST_BODY, pos_in_body, "body position out of frame")
  `RRFP_ASSERT_NEXT(a_last_done, push_tgt && tgt_last, hunt_last, "readout did not end")
  `RRFP_ASSERT_NEXT(a_err_out, push_err, err_shown, "rejected frame gave no error result")

endmodule

// ----- rtl/rrfp_ram.sv -----
module rrfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 30,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- sim/tb_radar_report_frame_parser.sv -----
`timescale 1ns / 100ps

module tb_radar_report_frame_parser;
  import rrfp_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 40;

  localparam logic [7:0] HEADER [HDR_LEN] = '{HDR_B0, HDR_B1, HDR_B2, HDR_B3};

  typedef struct packed {
    logic               frame_status;
    logic [1:0]         target_index;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] speed;
    logic [15:0]        distance_res;
    logic               target_valid;
    logic [1:0]         valid_count;
    logic [31:0]        good_frames;
    logic [31:0]        bad_frames;
    logic               last;
  } report_t;

  typedef logic [15:0] frame_words_t [NUM_TARGETS * 4];

  logic clk;
  logic rst_n;

  rrfp_in_if  in_ch();
  rrfp_out_if out_ch();

  radar_report_frame_parser dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser state as seen from the byte stream
  logic [7:0]  frame_bytes [FRAME_LEN];
  bit          in_body;
  int unsigned hdr_seen;
  int unsigned wr_pos;
  logic [31:0] good_total;
  logic [31:0] bad_total;
  report_t     pending_reports [$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatches;
  int bytes_sent;
  int reports_expected;
  int reports_checked;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic signed [15:0] sign_mag(input logic [7:0] lo, input logic [7:0] hi);
    logic [15:0] mag;
    mag = {1'b0, hi[6:0], lo};
    return hi[7] ? -mag : mag;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    report_t     rec [NUM_TARGETS];
    report_t     rej;
    int unsigned base;
    int unsigned count;
    if (!in_body) begin
      if (b == HEADER[hdr_seen]) begin
        frame_bytes[hdr_seen] = b;
        hdr_seen++;
        if (hdr_seen == HDR_LEN) begin
          in_body  = 1'b1;
          hdr_seen = 0;
          wr_pos   = HDR_LEN;
        end
      end else if (b == HEADER[0]) begin
        frame_bytes[0] = b;
        hdr_seen       = 1;
      end else begin
        hdr_seen = 0;
      end
      return;
    end
    frame_bytes[wr_pos] = b;
    wr_pos++;
    if (wr_pos < FRAME_LEN) return;
    in_body = 1'b0;
    wr_pos  = 0;
    if (frame_bytes[FRAME_LEN-2] != TAIL_B0 || frame_bytes[FRAME_LEN-1] != TAIL_B1) begin
      bad_total        = bad_total + 32'd1;
      rej              = '0;
      rej.frame_status = 1'b1;
      rej.good_frames  = good_total;
      rej.bad_frames   = bad_total;
      rej.last         = 1'b1;
      pending_reports.push_back(rej);
      reports_expected++;
      return;
    end
    good_total = good_total + 32'd1;
    count      = 0;
    for (int t = 0; t < NUM_TARGETS; t++) begin
      base                  = HDR_LEN + t * REC_LEN;
      rec[t]                = '0;
      rec[t].target_index   = t[1:0];
      rec[t].pos_x          = sign_mag(frame_bytes[base],   frame_bytes[base+1]);
      rec[t].pos_y          = sign_mag(frame_bytes[base+2], frame_bytes[base+3]);
      rec[t].speed          = sign_mag(frame_bytes[base+4], frame_bytes[base+5]);
      rec[t].distance_res   = {frame_bytes[base+7], frame_bytes[base+6]};
      rec[t].target_valid   = (rec[t].pos_x != 0) || (rec[t].pos_y != 0) ||
                              (rec[t].speed != 0) || (rec[t].distance_res != 0);
      rec[t].good_frames    = good_total;
      rec[t].bad_frames     = bad_total;
      rec[t].last           = (t == NUM_TARGETS - 1);
      count += rec[t].target_valid;
    end
    for (int t = 0; t < NUM_TARGETS; t++) begin
      rec[t].valid_count = count[1:0];
      pending_reports.push_back(rec[t]);
      reports_expected++;
    end
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 'h%0h, got 'h%0h", field, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : check_reports
    report_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_reports.size() == 0) begin
        $error("report arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        check_field("frame_status", want.frame_status, out_ch.frame_status);
        check_field("target_index", want.target_index, out_ch.target_index);
        check_field("pos_x",        want.pos_x,        out_ch.pos_x);
        check_field("pos_y",        want.pos_y,        out_ch.pos_y);
        check_field("speed",        want.speed,        out_ch.speed);
        check_field("distance_res", want.distance_res, out_ch.distance_res);
        check_field("target_valid", want.target_valid, out_ch.target_valid);
        check_field("valid_count",  want.valid_count,  out_ch.valid_count);
        check_field("good_frames",  want.good_frames,  out_ch.good_frames);
        check_field("bad_frames",   want.bad_frames,   out_ch.bad_frames);
        check_field("last",         want.last,         out_ch.last);
        reports_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    absorb_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_body(input frame_words_t words, input logic [7:0] tail0,
                           input logic [7:0] tail1);
    foreach (words[i]) begin
      send_byte(words[i][7:0]);
      send_byte(words[i][15:8]);
    end
    send_byte(tail0);
    send_byte(tail1);
  endtask

  task automatic send_frame(input frame_words_t words, input logic [7:0] tail0,
                            input logic [7:0] tail1);
    foreach (HEADER[i]) send_byte(HEADER[i]);
    send_body(words, tail0, tail1);
  endtask

  // header hunt: stray bytes, a broken header, and an AA mismatch restarting the match
  task automatic run_header_hunt();
    logic [7:0]   lead [12] = '{8'h12, HDR_B0, HDR_B1, HDR_B2, TAIL_B0, HDR_B0, HDR_B1,
                                HDR_B0, HDR_B0, HDR_B1, HDR_B2, HDR_B3};
    frame_words_t words = '{default: 16'h0000};
    words[0] = 16'h0001;
    words[1] = 16'h0002;
    words[2] = 16'h0003;
    words[3] = 16'h0004;
    foreach (lead[i]) send_byte(lead[i]);
    send_body(words, TAIL_B0, TAIL_B1);
  endtask

  // extreme magnitudes, negative zero, all-zero slots and single nonzero fields
  task automatic run_sign_decode();
    frame_words_t words;
    words = '{16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFF,
              16'h0000, 16'h0000, 16'h0000, 16'h0000,
              16'h8000, 16'h8000, 16'h8000, 16'h0000};
    send_frame(words, TAIL_B0, TAIL_B1);
    words = '{16'h0000, 16'h8000, 16'h0000, 16'h0100,
              16'h8000, 16'h0000, 16'h0001, 16'h0000,
              16'h8001, 16'h0000, 16'h8000, 16'h0000};
    send_frame(words, TAIL_B0, TAIL_B1);
  endtask

  // rejected frames: each tail byte wrong on its own
  task automatic run_bad_tail();
    frame_words_t words;
    foreach (words[i]) words[i] = 16'($urandom_range(16'hFFFF));
    send_frame(words, TAIL_B0, 8'h00);
    foreach (words[i]) words[i] = 16'($urandom_range(16'hFFFF));
    send_frame(words, TAIL_B1, TAIL_B1);
  endtask

  function automatic logic [15:0] random_word();
    logic [15:0] w;
    case ($urandom_range(7))
      0: w = 16'h0000;
      1: w = 16'h8000;
      2: w = 16'h7FFF;
      3: w = 16'hFFFF;
      4: w = {1'($urandom_range(1)), 15'h0000} | 16'($urandom_range(3));
      default: w = 16'($urandom_range(16'hFFFF));
    endcase
    return w;
  endfunction

  function automatic logic [7:0] noise_byte();
    return ($urandom_range(3) == 0) ? HDR_B0 : 8'($urandom_range(255));
  endfunction

  task automatic run_random_traffic(input int min_bytes, input int min_reports);
    frame_words_t words;
    logic [7:0]   tail0;
    logic [7:0]   tail1;
    int           byte_goal;
    int           report_goal;
    int           pick;
    byte_goal   = bytes_sent + min_bytes;
    report_goal = reports_expected + min_reports;
    while (bytes_sent < byte_goal || reports_expected < report_goal) begin
      pick = $urandom_range(19);
      if (pick < 15) begin
        repeat ($urandom_range(2)) send_byte(noise_byte());
        for (int t = 0; t < NUM_TARGETS; t++) begin
          if ($urandom_range(4) == 0) begin
            for (int k = 0; k < 4; k++) words[t*4+k] = 16'h0000;
          end else begin
            for (int k = 0; k < 4; k++) words[t*4+k] = random_word();
          end
        end
        case ($urandom_range(9))
          8: begin
            tail0 = TAIL_B0;
            tail1 = 8'($urandom_range(255));
          end
          9: begin
            tail0 = 8'($urandom_range(255));
            tail1 = 8'($urandom_range(255));
          end
          default: begin
            tail0 = TAIL_B0;
            tail1 = TAIL_B1;
          end
        endcase
        send_frame(words, tail0, tail1);
      end else if (pick < 18) begin
        for (int i = 0; i < $urandom_range(1, HDR_LEN - 1); i++) send_byte(HEADER[i]);
        send_byte(noise_byte());
      end else begin
        repeat ($urandom_range(1, 6)) send_byte(noise_byte());
      end
      if ($urandom_range(7) == 0) wait_drained();
    end
  endtask

  initial begin
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready  = 1'b0;
    rst_n         = 1'b0;
    send_idle_pct = 36;
    recv_idle_pct = 78;
    in_body       = 1'b0;
    hdr_seen      = 0;
    wr_pos        = 0;
    good_total    = '0;
    bad_total     = '0;
    mismatches    = 0;
    bytes_sent    = 0;
    reports_expected = 0;
    reports_checked  = 0;
    quiet_cycles  = 0;
    foreach (frame_bytes[i]) frame_bytes[i] = 8'h00;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    run_header_hunt();
    run_sign_decode();
    run_bad_tail();
    run_random_traffic(60, 3);
    wait_drained();

    send_idle_pct = 78;
    recv_idle_pct = 36;
    run_random_traffic(60, 3);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_traffic(60, 3);
    wait_drained();

    $display("covered %0d bytes: %0d good frames, %0d rejected frames", bytes_sent,
             good_total, bad_total);
    $display("checked %0d reports under three sender/receiver stall mixes", reports_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
